### rtl/sbs_pkg.sv
package sbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = 11;
  localparam int IDX_W       = 10;
  localparam int DATA_W      = 32;
  localparam int FUNC_W      = 2;
  localparam int STEP_W      = 2;

  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOWER = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_UPPER = 2'd2;

  localparam logic [DATA_W-1:0] SIGN_BIAS = {1'b1, {(DATA_W-1){1'b0}}};

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_FETCH  = 2'd0;
  localparam step_t STEP_PROBE  = 2'd1;
  localparam step_t STEP_UPDATE = 2'd2;
  localparam step_t STEP_EMIT   = 2'd3;

  typedef enum logic [1:0] {
    COND_GOTO,
    COND_NOT_QUERY,
    COND_EMPTY,
    COND_BUSY
  } cond_t;

  typedef struct packed {
    logic accept;
    logic rd;
    logic upd;
    logic emit;
  } seq_ctrl_t;

  typedef struct packed {
    logic query_acc;
    logic empty;
    logic out_busy;
  } seq_stat_t;

  typedef struct packed {
    seq_ctrl_t ctl;
    cond_t     cond;
    step_t     jump;
    step_t     next;
  } ucode_word_t;

  // cond true -> jump, else next
  function automatic ucode_word_t ucode_rom(step_t s);
    ucode_word_t w;
    w = '{ctl: '0, cond: COND_GOTO, jump: STEP_FETCH, next: STEP_FETCH};
    unique case (s)
      STEP_FETCH:  w = '{ctl: '{accept: 1'b1, rd: 1'b0, upd: 1'b0, emit: 1'b0},
                         cond: COND_NOT_QUERY, jump: STEP_FETCH, next: STEP_PROBE};
      STEP_PROBE:  w = '{ctl: '{accept: 1'b0, rd: 1'b1, upd: 1'b0, emit: 1'b0},
                         cond: COND_EMPTY, jump: STEP_EMIT, next: STEP_UPDATE};
      STEP_UPDATE: w = '{ctl: '{accept: 1'b0, rd: 1'b0, upd: 1'b1, emit: 1'b0},
                         cond: COND_GOTO, jump: STEP_PROBE, next: STEP_PROBE};
      STEP_EMIT:   w = '{ctl: '{accept: 1'b0, rd: 1'b0, upd: 1'b0, emit: 1'b1},
                         cond: COND_BUSY, jump: STEP_EMIT, next: STEP_FETCH};
      default:     w = '{ctl: '0, cond: COND_GOTO, jump: STEP_FETCH, next: STEP_FETCH};
    endcase
    return w;
  endfunction

endpackage

### rtl/sbs_ram.sv
module sbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/sbs_sequencer.sv
module sbs_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  sbs_pkg::seq_stat_t  stat,
  output sbs_pkg::seq_ctrl_t  ctl
);

  sbs_pkg::step_t       step_r;
  sbs_pkg::step_t       step_nxt;
  sbs_pkg::ucode_word_t word;
  logic                 cond_hit;

  assign word = sbs_pkg::ucode_rom(step_r);
  assign ctl  = word.ctl;

  always_comb begin
    unique case (word.cond)
      sbs_pkg::COND_GOTO:      cond_hit = 1'b1;
      sbs_pkg::COND_NOT_QUERY: cond_hit = !stat.query_acc;
      sbs_pkg::COND_EMPTY:     cond_hit = stat.empty;
      sbs_pkg::COND_BUSY:      cond_hit = stat.out_busy;
      default:                 cond_hit = 1'b1;
    endcase
    step_nxt = cond_hit ? word.jump : word.next;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= sbs_pkg::STEP_FETCH;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

### rtl/sbs_datapath.sv
module sbs_datapath (
  input  logic                         clk,
  input  sbs_pkg::seq_ctrl_t           ctl,
  input  logic                         load,
  input  logic                         upper_in,
  input  logic [sbs_pkg::DATA_W-1:0]   key_in,
  input  logic [sbs_pkg::CNT_W-1:0]    live_cnt,
  input  logic                         wr_en,
  input  logic [sbs_pkg::ADDR_W-1:0]   wr_addr,
  input  logic [sbs_pkg::DATA_W-1:0]   wr_data,
  output logic                         empty,
  output logic [sbs_pkg::CNT_W-1:0]    lo
);

  logic [sbs_pkg::CNT_W-1:0]  lo_r;
  logic [sbs_pkg::CNT_W-1:0]  hi_r;
  logic [sbs_pkg::CNT_W-1:0]  mid_r;
  logic [sbs_pkg::CNT_W-1:0]  span;
  logic [sbs_pkg::CNT_W-1:0]  mid_c;
  logic [sbs_pkg::DATA_W-1:0] key_r;
  logic                       upper_r;
  logic [sbs_pkg::DATA_W-1:0] entry;
  logic                       go_right;

  assign span     = hi_r - lo_r;
  assign mid_c    = lo_r + (span >> 1);
  assign empty    = !(lo_r < hi_r);
  assign lo       = lo_r;
  // keys and entries are sign-flipped, so unsigned compare gives signed order
  assign go_right = upper_r ? (key_r >= entry) : (key_r > entry);

  sbs_ram #(
    .WIDTH (sbs_pkg::DATA_W),
    .DEPTH (sbs_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (ctl.rd),
    .raddr (sbs_pkg::ADDR_W'(mid_c)),
    .rdata (entry)
  );

  always_ff @(posedge clk) begin
    if (load) begin
      lo_r    <= '0;
      hi_r    <= live_cnt;
      key_r   <= key_in;
      upper_r <= upper_in;
    end else if (ctl.upd) begin
      if (go_right) begin
        lo_r <= mid_r + sbs_pkg::CNT_W'(1);
      end else begin
        hi_r <= mid_r;
      end
    end
    if (ctl.rd) begin
      mid_r <= mid_c;
    end
  end

endmodule

### rtl/sorted_table_bound_search.sv
// channel | ports                                   | dir
// in      | in_valid in_stall in_func in_entry_index in_value | sink
// out     | out_valid out_stall out_position        | source
// cfg     | cfg_wr_en cfg_wr_data                   | sink
//
// Write word: taken straight into the table RAM.
// Query word: an accept step, then per halving step a RAM read, then compare
//   and update, over at most ceil(log2(count+1)) steps, then a final probe and the emit.
// Reset clears the count and the sequencer; table contents stay undefined, no clearing pass.
// The result register frees the input side: the next word is taken while a
//   result waits; a query finishing early holds in its last step until it frees.
module sorted_table_bound_search (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [sbs_pkg::FUNC_W-1:0]   in_func,
  input  logic [sbs_pkg::IDX_W-1:0]    in_entry_index,
  input  logic signed [sbs_pkg::DATA_W-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sbs_pkg::CNT_W-1:0]    out_position,
  input  logic                         cfg_wr_en,
  input  logic [sbs_pkg::CNT_W-1:0]    cfg_wr_data
);

  sbs_pkg::seq_ctrl_t         ctl;
  sbs_pkg::seq_stat_t         stat;
  logic [sbs_pkg::CNT_W-1:0]  count_r;
  logic [sbs_pkg::CNT_W-1:0]  live_cnt;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic [sbs_pkg::CNT_W-1:0]  position_r;
  logic                       acc;
  logic                       is_query;
  logic                       wr_en;
  logic                       empty;
  logic                       emit_go;
  logic [sbs_pkg::CNT_W-1:0]  lo;
  logic [sbs_pkg::DATA_W-1:0] key_biased;

  assign live_cnt = (32'(count_r) > 32'(sbs_pkg::TABLE_DEPTH)) ?
                    sbs_pkg::CNT_W'(sbs_pkg::TABLE_DEPTH) : count_r;

  assign in_stall   = !ctl.accept;
  assign acc        = in_valid && ctl.accept;
  assign is_query   = (in_func == sbs_pkg::FUNC_LOWER) || (in_func == sbs_pkg::FUNC_UPPER);
  assign wr_en      = acc && (in_func == sbs_pkg::FUNC_WRITE) &&
                      (32'(in_entry_index) < 32'(sbs_pkg::TABLE_DEPTH));
  assign key_biased = in_value ^ sbs_pkg::SIGN_BIAS;

  assign stat.query_acc = acc && is_query;
  assign stat.empty     = empty;
  assign stat.out_busy  = out_valid_r && out_stall;

  assign emit_go       = ctl.emit && !stat.out_busy;
  assign out_valid_nxt = emit_go || (out_valid_r && out_stall);

  sbs_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  sbs_datapath u_dp (
    .clk      (clk),
    .ctl      (ctl),
    .load     (stat.query_acc),
    .upper_in (in_func == sbs_pkg::FUNC_UPPER),
    .key_in   (key_biased),
    .live_cnt (live_cnt),
    .wr_en    (wr_en),
    .wr_addr  (sbs_pkg::ADDR_W'(in_entry_index)),
    .wr_data  (key_biased),
    .empty    (empty),
    .lo       (lo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        count_r <= cfg_wr_data;
      end
      out_valid_r <= out_valid_nxt;
    end
    if (emit_go) begin
      position_r <= lo;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_position = position_r;

`ifndef ASSERT_OFF
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_position <= live_cnt))
    else $error("bound position beyond live count");

  a_upd_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.upd |-> !empty)
    else $error("halving update on empty range");

  a_query_locks_input: assert property (@(posedge clk) disable iff (!rst_n)
    stat.query_acc |=> in_stall)
    else $error("input taken while a query runs");
`endif

endmodule

### tb/tb_sorted_table_bound_search.sv
module tb_sorted_table_bound_search;

  localparam logic [sbs_pkg::FUNC_W-1:0] FUNC_IGNORED = 2'd3;
  localparam logic signed [sbs_pkg::DATA_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [sbs_pkg::DATA_W-1:0] KEY_MAX = 32'sh7fff_ffff;
  localparam logic signed [11:0] POS_COMPUTED = -12'sd1;
  localparam int SETTLE_CYCLES = 30;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TRAFFIC_WORDS = 850;
  localparam int SPARSE_ABOVE = 128;
  localparam int END_BLOCK = 8;
  localparam int KEY_TRIES = 8;
  localparam int PLAN_LEN = 13;
  localparam int COUNT_PLAN [PLAN_LEN] = '{1, 2, 1024, 3, 2047, 7, 0, 16, 1025, 64,
                                           1023, 33, 500};

  typedef struct packed {
    logic                             cfg;
    logic [sbs_pkg::FUNC_W-1:0]       func;
    logic [sbs_pkg::IDX_W-1:0]        idx;
    logic signed [sbs_pkg::DATA_W-1:0] val;
    logic signed [11:0]               pos;
  } stim_row_t;

  // cfg rows carry the new table count in val
  localparam stim_row_t DIRECTED [24] = '{
    '{1'b1, sbs_pkg::FUNC_WRITE, 10'd0,   32'sd0,  POS_COMPUTED},
    '{1'b0, sbs_pkg::FUNC_LOWER, 10'd0,   32'sd0,  12'sd0},
    '{1'b0, sbs_pkg::FUNC_UPPER, 10'h3ff, KEY_MAX, 12'sd0},
    '{1'b0, FUNC_IGNORED,        10'h3ff, -32'sd1, POS_COMPUTED},
    '{1'b0, sbs_pkg::FUNC_WRITE, 10'd0,   KEY_MIN, POS_COMPUTED},
    '{1'b0, sbs_pkg::FUNC_WRITE, 10'd1,   -32'sd5, POS_COMPUTED},
    '{1'b0, sbs_pkg::FUNC_WRITE, 10'd2,   32'sd0,  POS_COMPUTED},
    '{1'b0, sbs_pkg::FUNC_WRITE, 10'd3,   32'sd0,  POS_COMPUTED},
    '{1'b0, sbs_pkg::FUNC_WRITE, 10'd4,   32'sd7,  POS_COMPUTED},
    '{1'b0, sbs_pkg::FUNC_WRITE, 10'd5,   KEY_MAX, POS_COMPUTED},
    '{1'b0, sbs_pkg::FUNC_WRITE, 10'h3ff, KEY_MAX, POS_COMPUTED},
    '{1'b1, sbs_pkg::FUNC_WRITE, 10'd0,   32'sd6,  POS_COMPUTED},
    '{1'b0, sbs_pkg::FUNC_LOWER, 10'd0,   KEY_MIN, 12'sd0},
    '{1'b0, sbs_pkg::FUNC_UPPER, 10'd0,   KEY_MIN, 12'sd1},
    '{1'b0, sbs_pkg::FUNC_LOWER, 10'd0,   32'sd0,  12'sd2},
    '{1'b0, sbs_pkg::FUNC_UPPER, 10'd0,   32'sd0,  12'sd4},
    '{1'b0, sbs_pkg::FUNC_LOWER, 10'h3ff, KEY_MAX, 12'sd5},
    '{1'b0, sbs_pkg::FUNC_UPPER, 10'h3ff, KEY_MAX, 12'sd6},
    '{1'b0, sbs_pkg::FUNC_LOWER, 10'd0,   32'sd8,  POS_COMPUTED},
    '{1'b0, sbs_pkg::FUNC_UPPER, 10'd0,   -32'sd6, POS_COMPUTED},
    '{1'b1, sbs_pkg::FUNC_WRITE, 10'd0,   32'sd1,  POS_COMPUTED},
    '{1'b0, sbs_pkg::FUNC_LOWER, 10'd0,   KEY_MAX, 12'sd1},
    '{1'b0, sbs_pkg::FUNC_UPPER, 10'd0,   KEY_MIN, 12'sd1},
    '{1'b0, sbs_pkg::FUNC_LOWER, 10'd0,   KEY_MIN, 12'sd0}
  };

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_stall;
  logic [sbs_pkg::FUNC_W-1:0]        in_func;
  logic [sbs_pkg::IDX_W-1:0]         in_entry_index;
  logic signed [sbs_pkg::DATA_W-1:0] in_value;
  logic                              out_valid;
  logic                              out_stall;
  logic [sbs_pkg::CNT_W-1:0]         out_position;
  logic                              cfg_wr_en;
  logic [sbs_pkg::CNT_W-1:0]         cfg_wr_data;

  logic signed [sbs_pkg::DATA_W-1:0] table_mem [sbs_pkg::TABLE_DEPTH];
  bit                                entry_written [sbs_pkg::TABLE_DEPTH];
  logic [sbs_pkg::CNT_W-1:0]         table_count;
  logic [sbs_pkg::CNT_W-1:0]         pending_positions [$];

  bit calm;
  bit hold_req;
  int errors = 0;
  int n_sent = 0;
  int n_lower = 0;
  int n_upper = 0;
  int n_writes = 0;
  int n_ignored = 0;
  int n_configs = 0;
  int n_holds = 0;
  int n_checked = 0;

  sorted_table_bound_search i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_entry_index (in_entry_index),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_position   (out_position),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned pick_gap(bit quiet_side);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_side || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int live_of(logic [sbs_pkg::CNT_W-1:0] cnt);
    return (cnt > sbs_pkg::TABLE_DEPTH) ? sbs_pkg::TABLE_DEPTH : int'(cnt);
  endfunction

  // halving search over [0, count), midpoint rounded down, count saturated to depth
  function automatic logic [sbs_pkg::CNT_W-1:0] bound_of(logic signed [sbs_pkg::DATA_W-1:0] key,
                                                          bit upper);
    int lo, hi, mid;
    lo = 0;
    hi = live_of(table_count);
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (upper ? (key >= table_mem[mid]) : (key > table_mem[mid])) lo = mid + 1;
      else hi = mid;
    end
    return sbs_pkg::CNT_W'(lo);
  endfunction

  // same walk, true when every probed entry holds a written value
  function automatic bit path_written(logic signed [sbs_pkg::DATA_W-1:0] key, bit upper);
    int lo, hi, mid;
    lo = 0;
    hi = live_of(table_count);
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (!entry_written[mid]) return 1'b0;
      if (upper ? (key >= table_mem[mid]) : (key > table_mem[mid])) lo = mid + 1;
      else hi = mid;
    end
    return 1'b1;
  endfunction

  function automatic logic signed [sbs_pkg::DATA_W-1:0] pick_key(int live);
    int r;
    int k;
    r = $urandom_range(0, 9);
    k = (live > 0) ? int'($urandom_range(0, live - 1)) : 0;
    if (r < 5 && live > 0 && entry_written[k])
      return sbs_pkg::DATA_W'(table_mem[k] + $urandom_range(0, 2) - 1);
    if (r < 7) return sbs_pkg::DATA_W'($urandom);
    if (r == 7) return KEY_MIN;
    if (r == 8) return KEY_MAX;
    return sbs_pkg::DATA_W'($urandom_range(0, 40) - 20);
  endfunction

  task automatic record_word(logic [sbs_pkg::FUNC_W-1:0] func, logic [sbs_pkg::IDX_W-1:0] idx,
                             logic signed [sbs_pkg::DATA_W-1:0] val, logic signed [11:0] pos);
    n_sent++;
    case (func) inside
      sbs_pkg::FUNC_WRITE: begin
        table_mem[idx] = val;
        entry_written[idx] = 1'b1;
        n_writes++;
      end
      sbs_pkg::FUNC_LOWER, sbs_pkg::FUNC_UPPER: begin
        if (pos == POS_COMPUTED)
          pending_positions.push_back(bound_of(val, func == sbs_pkg::FUNC_UPPER));
        else pending_positions.push_back(pos[sbs_pkg::CNT_W-1:0]);
        if (func == sbs_pkg::FUNC_UPPER) n_upper++;
        else n_lower++;
      end
      default: n_ignored++;
    endcase
  endtask

  // called at a falling edge; returns at a falling edge with valid still high if no gap
  task automatic send_word(logic [sbs_pkg::FUNC_W-1:0] func, logic [sbs_pkg::IDX_W-1:0] idx,
                           logic signed [sbs_pkg::DATA_W-1:0] val, logic signed [11:0] pos);
    int unsigned gap;
    in_valid       <= 1'b1;
    in_func        <= func;
    in_entry_index <= idx;
    in_value       <= val;
    do @(posedge clk); while (in_stall);
    record_word(func, idx, val, pos);
    @(negedge clk);
    gap = pick_gap(calm);
    if (gap != 0) begin
      in_valid       <= 1'b0;
      in_func        <= sbs_pkg::FUNC_W'($urandom);
      in_entry_index <= sbs_pkg::IDX_W'($urandom);
      in_value       <= sbs_pkg::DATA_W'($urandom);
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_positions.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_table_count(logic [sbs_pkg::CNT_W-1:0] n);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= n;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    table_count = n;
    n_configs++;
  endtask

  // small tables are written whole; large ones only on both search spines and at both ends
  task automatic fill_table(int live, bit sorted);
    int idxs [$];
    int vals [$];
    bit pick [sbs_pkg::TABLE_DEPTH];
    int lo, hi, mid, r;
    if (live <= SPARSE_ABOVE) begin
      for (int i = 0; i < live; i++) pick[i] = 1'b1;
    end else begin
      lo = 0;
      hi = live;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        pick[mid] = 1'b1;
        hi = mid;
      end
      lo = 0;
      hi = live;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        pick[mid] = 1'b1;
        lo = mid + 1;
      end
      for (int i = 0; i < END_BLOCK; i++) begin
        pick[i] = 1'b1;
        pick[live - 1 - i] = 1'b1;
      end
    end
    for (int i = 0; i < live; i++) if (pick[i]) idxs.push_back(i);
    foreach (idxs[i]) begin
      r = $urandom_range(0, 9);
      if (r < 3 && vals.size() != 0) vals.push_back(vals[$urandom_range(0, vals.size() - 1)]);
      else if (r < 6) vals.push_back(int'($urandom_range(0, 40)) - 20);
      else if (r == 9) vals.push_back($urandom_range(0, 1) ? KEY_MIN : KEY_MAX);
      else vals.push_back(int'($urandom));
    end
    if (sorted) vals.sort();
    foreach (idxs[i])
      send_word(sbs_pkg::FUNC_WRITE, sbs_pkg::IDX_W'(idxs[i]), vals[i], POS_COMPUTED);
  endtask

  // receiver backpressure
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        n_holds++;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        if (stall_left == 0) stall_left = pick_gap(calm);
        if (stall_left != 0) begin
          out_stall <= 1'b1;
          stall_left--;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin
    logic [sbs_pkg::CNT_W-1:0] exp_pos;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_positions.size() == 0) begin
          errors++;
          if (errors < 50)
            $display("%0t: expected no word, got position %0d", $time, out_position);
        end else begin
          exp_pos = pending_positions.pop_front();
          n_checked++;
          if (out_position !== exp_pos) begin
            errors++;
            if (errors < 50)
              $display("%0t: position expected %0d, got %0d", $time, exp_pos, out_position);
          end
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) quiet = 0;
      else quiet++;
    end
    $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    int phase, n, live, words, r;
    bit fresh;
    bit upper;
    logic signed [sbs_pkg::DATA_W-1:0] key;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_func        = sbs_pkg::FUNC_WRITE;
    in_entry_index = '0;
    in_value       = '0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    calm           = 1'b0;
    hold_req       = 1'b0;
    table_count    = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].cfg) set_table_count(DIRECTED[i].val[sbs_pkg::CNT_W-1:0]);
      else send_word(DIRECTED[i].func, DIRECTED[i].idx, DIRECTED[i].val, DIRECTED[i].pos);
    end

    phase = 0;
    while (n_sent < TRAFFIC_WORDS) begin
      if (phase < PLAN_LEN) n = COUNT_PLAN[phase];
      else if ($urandom_range(0, 7) == 0) n = $urandom_range(0, 2047);
      else n = $urandom_range(1, 64);
      live = (n > sbs_pkg::TABLE_DEPTH) ? sbs_pkg::TABLE_DEPTH : n;
      calm = ($urandom_range(0, 3) == 0);

      fresh = 1'b0;
      for (int i = 0; i < live; i++) if (!entry_written[i]) fresh = 1'b1;
      if (fresh || (live <= SPARSE_ABOVE && $urandom_range(0, 3) != 0))
        fill_table(live, live > SPARSE_ABOVE || $urandom_range(0, 7) != 0);
      set_table_count(sbs_pkg::CNT_W'(n));

      if (phase == 4 || $urandom_range(0, 11) == 0) begin
        hold_req = 1'b1;
        calm = 1'b1;
      end

      words = $urandom_range(15, 40);
      for (int k = 0; k < words && n_sent < TRAFFIC_WORDS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          send_word(FUNC_IGNORED, sbs_pkg::IDX_W'($urandom), sbs_pkg::DATA_W'($urandom),
                    POS_COMPUTED);
        end else if (r < 16 && live < sbs_pkg::TABLE_DEPTH) begin
          send_word(sbs_pkg::FUNC_WRITE,
                    sbs_pkg::IDX_W'($urandom_range(live, sbs_pkg::TABLE_DEPTH - 1)),
                    sbs_pkg::DATA_W'($urandom), POS_COMPUTED);
        end else if (r < 22) begin
          send_word(sbs_pkg::FUNC_WRITE, sbs_pkg::IDX_W'($urandom),
                    sbs_pkg::DATA_W'($urandom), POS_COMPUTED);
        end else begin
          // only keys whose search probes written entries; the left spine always is
          upper = $urandom_range(0, 1);
          key = pick_key(live);
          for (int t = 0; t < KEY_TRIES && !path_written(key, upper); t++) key = pick_key(live);
          if (!path_written(key, upper)) begin
            key = KEY_MIN;
            upper = 1'b0;
          end
          send_word(upper ? sbs_pkg::FUNC_UPPER : sbs_pkg::FUNC_LOWER,
                    sbs_pkg::IDX_W'($urandom), key, POS_COMPUTED);
        end
      end
      phase++;
    end

    wait_idle();
    $display("Run covered %0d lower and %0d upper bound queries (%0d results checked),",
             n_lower, n_upper, n_checked);
    $display("%0d writes, %0d ignored words; count set %0d times over %0d phases, held off %0d times.",
             n_writes, n_ignored, n_configs, phase, n_holds);
    if (errors == 0 && pending_positions.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
